FILE: rtl/protected_event_log_buffer_top_assert.svh
// Assertion macros for the event log buffer.
`ifndef PROTECTED_EVENT_LOG_BUFFER_TOP_ASSERT_SVH
`define PROTECTED_EVENT_LOG_BUFFER_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define PELB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define PELB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pelb_pkg.sv
// ----------------------------------------------------------------------------
// pelb_pkg
// Types and codes shared by the event log buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pelb_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_APPEND,
        S_QUERY
    } t_state;

    typedef struct packed {
        logic [31:0] cursor;
        logic [1:0]  phase;
        logic [31:0] payload;
        logic [15:0] bytes;
    } t_rec;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_BAD_PHASE = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;
    localparam logic [2:0] ST_FULL_PROT = 3'd5;

    localparam logic [1:0] PH_UPDATE  = 2'd1;
    localparam logic [1:0] PH_INVALID = 2'd3;

    localparam logic [1:0] REG_RECORD_LIMIT = 2'd0;
    localparam logic [1:0] REG_BYTE_LIMIT   = 2'd1;

endpackage
`default_nettype wire

FILE: rtl/pelb_mem.sv
// ----------------------------------------------------------------------------
// pelb_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pelb_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire                 i_clk,
    input  wire                 i_wr_en,
    input  wire [AW-1:0]        i_wr_addr,
    input  wire pelb_pkg::t_rec i_wr_data,
    input  wire                 i_rd_en,
    input  wire [AW-1:0]        i_rd_addr,
    output pelb_pkg::t_rec      o_rd_data
);
    import pelb_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

FILE: rtl/protected_event_log_buffer_top.sv
// ----------------------------------------------------------------------------
// protected_event_log_buffer_top
// Ordered event log bounded by record count and byte budget.
// ----------------------------------------------------------------------------
// An append that fits goes through the append state; one that needs
// evictions walks the record store twice (search, then compaction). A
// query walks the store once, one record a cycle, then the summary. The
// walk speed is set by the single read port of the store.
// Results appear on o_strobe for one cycle and cannot be held off; the
// receiver must take each one. Configuration writes are accepted at once
// but only belong while busy is low.
`default_nettype none
module protected_event_log_buffer_top #(
    parameter int DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_mode,
    input  wire  [1:0]  i_phase,
    input  wire  [31:0] i_payload,
    input  wire  [15:0] i_record_size,
    input  wire  [31:0] i_after_cursor,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [31:0] o_cursor,
    output logic [1:0]  o_record_phase,
    output logic [31:0] o_record_payload,
    output logic [31:0] o_oldest_kept,
    output logic [31:0] o_newest_cursor,
    output logic [31:0] o_latest_assigned,
    output logic        o_cursor_gap,
    output logic [31:0] o_update_drops,
    output logic        o_last
);
    import pelb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // width of the byte total of a full store of maximum-size records
    localparam int BW = $clog2(DEPTH * 65535 + 1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [BW-1:0] r_bytes, n_bytes;
    logic [31:0] r_cursor, n_cursor;
    logic [31:0] r_dropped, n_dropped;
    logic [5:0]  r_rec_limit;
    logic [31:0] r_byte_limit;

    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_payload, n_payload;
    logic [15:0] r_size, n_size;
    logic [31:0] r_after, n_after;

    logic [CW-1:0] r_ridx, n_ridx;
    logic        r_pv, n_pv;
    logic [CW-1:0] r_keep_n, n_keep_n;
    logic [BW-1:0] r_keep_b, n_keep_b;
    logic [CW-1:0] r_evict_n, n_evict_n;
    logic [CW-1:0] r_upd_seen, n_upd_seen;
    logic [CW-1:0] r_wj, n_wj;
    logic [31:0] r_prev, n_prev;
    logic        r_gap, n_gap;
    logic [31:0] r_oldest, n_oldest;
    logic [31:0] r_newest, n_newest;
    logic        r_first, n_first;

    logic        r_ov, n_ov;
    logic [1:0]  r_okind, n_okind;
    logic [2:0]  r_ostatus, n_ostatus;
    logic [31:0] r_ocursor, n_ocursor;
    logic [1:0]  r_ophase, n_ophase;
    logic [31:0] r_opayload, n_opayload;
    logic [31:0] r_ooldest, n_ooldest;
    logic [31:0] r_onewest, n_onewest;
    logic [31:0] r_olatest, n_olatest;
    logic        r_ogap, n_ogap;
    logic [31:0] r_odropped, n_odropped;
    logic        r_olast, n_olast;

    logic        mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    t_rec        mem_wr_data, mem_rd_data;

    logic        accept;
    logic [5:0]  lim;
    logic        walk_done;

    pelb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign lim         = (r_rec_limit > 6'(DEPTH)) ? 6'(DEPTH) : r_rec_limit;
    assign walk_done   = !r_pv && (r_ridx >= r_count);

    function automatic logic fits(input logic [CW-1:0] kn, input logic [BW-1:0] kb,
                                  input logic [5:0] lm, input logic [15:0] sz,
                                  input logic [31:0] bl);
        fits = ((7'(kn) + 7'd1) <= 7'(lm)) && ((33'(kb) + 33'(sz)) <= 33'(bl));
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == '1) ? v : v + 32'd1;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode) begin
                        n_state = S_QUERY;
                    end else if (i_phase == PH_INVALID || r_cursor == '1) begin
                        n_state = S_IDLE;
                    end else if (fits(r_count, r_bytes, lim, i_record_size,
                                      r_byte_limit)) begin
                        n_state = S_APPEND;
                    end else if (32'(i_record_size) > r_byte_limit) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pv && mem_rd_data.phase == PH_UPDATE &&
                    fits(r_keep_n - CW'(1), r_keep_b - BW'(mem_rd_data.bytes), lim,
                         r_size, r_byte_limit)) begin
                    n_state = S_COMPACT;
                end else if (walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_COMPACT: begin
                if (walk_done) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: n_state = S_IDLE;
            S_QUERY: begin
                if (walk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count    = r_count;
        n_bytes    = r_bytes;
        n_cursor   = r_cursor;
        n_dropped  = r_dropped;
        n_phase    = r_phase;
        n_payload  = r_payload;
        n_size     = r_size;
        n_after    = r_after;
        n_ridx     = r_ridx;
        n_pv       = 1'b0;
        n_keep_n   = r_keep_n;
        n_keep_b   = r_keep_b;
        n_evict_n  = r_evict_n;
        n_upd_seen = r_upd_seen;
        n_wj       = r_wj;
        n_prev     = r_prev;
        n_gap      = r_gap;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_first    = r_first;
        n_ov       = 1'b0;
        n_okind    = KIND_STATUS;
        n_ostatus  = ST_OK;
        n_ocursor  = '0;
        n_ophase   = '0;
        n_opayload = '0;
        n_ooldest  = '0;
        n_onewest  = '0;
        n_olatest  = '0;
        n_ogap     = 1'b0;
        n_odropped = '0;
        n_olast    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_wj[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_ridx[AW-1:0];

        // read issue for the walking states
        if ((r_state == S_SCAN || r_state == S_COMPACT || r_state == S_QUERY) &&
            r_ridx < r_count) begin
            mem_rd_en = 1'b1;
            n_ridx    = r_ridx + CW'(1);
            n_pv      = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_phase    = i_phase;
                    n_payload  = i_payload;
                    n_size     = i_record_size;
                    n_after    = i_after_cursor;
                    n_ridx     = '0;
                    n_keep_n   = r_count;
                    n_keep_b   = r_bytes;
                    n_evict_n  = '0;
                    n_upd_seen = '0;
                    n_wj       = '0;
                    n_prev     = i_after_cursor;
                    n_gap      = 1'b0;
                    n_oldest   = '0;
                    n_newest   = '0;
                    n_first    = 1'b1;
                    if (!i_mode) begin
                        if (i_phase == PH_INVALID) begin
                            n_ov = 1'b1; n_ostatus = ST_BAD_PHASE;
                        end else if (r_cursor == '1) begin
                            n_ov = 1'b1; n_ostatus = ST_EXHAUSTED;
                        end else if (!fits(r_count, r_bytes, lim, i_record_size,
                                           r_byte_limit) &&
                                     32'(i_record_size) > r_byte_limit) begin
                            n_ov = 1'b1;
                            if (i_phase == PH_UPDATE) begin
                                n_dropped = sat_inc(r_dropped);
                                n_ostatus = ST_DROPPED;
                            end else begin
                                n_ostatus = ST_TOO_LARGE;
                            end
                        end
                        n_olatest  = r_cursor;
                        n_odropped = n_dropped;
                        n_olast    = 1'b1;
                        n_okind    = KIND_STATUS;
                    end
                end
            end
            S_SCAN: begin
                // evictions are the oldest updates, taken in order
                if (r_pv && mem_rd_data.phase == PH_UPDATE) begin
                    n_keep_n  = r_keep_n - CW'(1);
                    n_keep_b  = r_keep_b - BW'(mem_rd_data.bytes);
                    n_evict_n = r_evict_n + CW'(1);
                    if (fits(n_keep_n, n_keep_b, lim, r_size, r_byte_limit)) begin
                        n_ridx = '0;
                        n_pv   = 1'b0;
                    end
                end else if (walk_done) begin
                    n_ov = 1'b1;
                    if (r_phase == PH_UPDATE) begin
                        n_dropped = sat_inc(r_dropped);
                        n_ostatus = ST_DROPPED;
                    end else begin
                        n_ostatus = ST_FULL_PROT;
                    end
                    n_olatest  = r_cursor;
                    n_odropped = n_dropped;
                    n_olast    = 1'b1;
                end
            end
            S_COMPACT: begin
                // write index never passes read index, so no overlap
                if (r_pv) begin
                    if (mem_rd_data.phase == PH_UPDATE) begin
                        n_upd_seen = r_upd_seen + CW'(1);
                    end
                    if (!(mem_rd_data.phase == PH_UPDATE && r_upd_seen < r_evict_n)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_wj[AW-1:0];
                        mem_wr_data = mem_rd_data;
                        n_wj        = r_wj + CW'(1);
                    end
                end else if (walk_done) begin
                    n_count = r_wj;
                    n_bytes = r_keep_b;
                end
            end
            S_APPEND: begin
                n_cursor            = r_cursor + 32'd1;
                mem_wr_en           = 1'b1;
                mem_wr_addr         = r_count[AW-1:0];
                mem_wr_data.cursor  = n_cursor;
                mem_wr_data.phase   = r_phase;
                mem_wr_data.payload = r_payload;
                mem_wr_data.bytes   = r_size;
                n_count             = r_count + CW'(1);
                n_bytes             = r_bytes + BW'(r_size);
                n_ov       = 1'b1;
                n_okind    = KIND_STATUS;
                n_ostatus  = ST_OK;
                n_ocursor  = n_cursor;
                n_olatest  = n_cursor;
                n_odropped = r_dropped;
                n_olast    = 1'b1;
            end
            S_QUERY: begin
                if (r_pv) begin
                    n_first  = 1'b0;
                    n_newest = mem_rd_data.cursor;
                    if (r_first) begin
                        n_oldest = mem_rd_data.cursor;
                    end
                    if (mem_rd_data.cursor > r_after) begin
                        if (mem_rd_data.cursor > r_prev &&
                            (mem_rd_data.cursor - r_prev) > 32'd1) begin
                            n_gap = 1'b1;
                        end
                        n_prev     = mem_rd_data.cursor;
                        n_ov       = 1'b1;
                        n_okind    = KIND_RECORD;
                        n_ocursor  = mem_rd_data.cursor;
                        n_ophase   = mem_rd_data.phase;
                        n_opayload = mem_rd_data.payload;
                    end
                end else if (walk_done) begin
                    n_ov       = 1'b1;
                    n_okind    = KIND_SUMMARY;
                    n_ooldest  = r_oldest;
                    n_onewest  = r_newest;
                    n_olatest  = r_cursor;
                    n_ogap     = r_gap;
                    n_odropped = r_dropped;
                    n_olast    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_bytes      <= '0;
            r_cursor     <= '0;
            r_dropped    <= '0;
            r_rec_limit  <= 6'd32;
            r_byte_limit <= 32'd65536;
            r_pv         <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
            r_cursor  <= n_cursor;
            r_dropped <= n_dropped;
            r_pv      <= n_pv;
            r_ov      <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_RECORD_LIMIT) begin
                    r_rec_limit <= i_cfg_data[5:0];
                end else if (i_cfg_index == REG_BYTE_LIMIT) begin
                    r_byte_limit <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_payload  <= n_payload;
        r_size     <= n_size;
        r_after    <= n_after;
        r_ridx     <= n_ridx;
        r_keep_n   <= n_keep_n;
        r_keep_b   <= n_keep_b;
        r_evict_n  <= n_evict_n;
        r_upd_seen <= n_upd_seen;
        r_wj       <= n_wj;
        r_prev     <= n_prev;
        r_gap      <= n_gap;
        r_oldest   <= n_oldest;
        r_newest   <= n_newest;
        r_first    <= n_first;
        r_okind    <= n_okind;
        r_ostatus  <= n_ostatus;
        r_ocursor  <= n_ocursor;
        r_ophase   <= n_ophase;
        r_opayload <= n_opayload;
        r_ooldest  <= n_ooldest;
        r_onewest  <= n_onewest;
        r_olatest  <= n_olatest;
        r_ogap     <= n_ogap;
        r_odropped <= n_odropped;
        r_olast    <= n_olast;
    end

    assign o_strobe          = r_ov;
    assign o_kind            = r_okind;
    assign o_status          = r_ostatus;
    assign o_cursor          = r_ocursor;
    assign o_record_phase    = r_ophase;
    assign o_record_payload  = r_opayload;
    assign o_oldest_kept     = r_ooldest;
    assign o_newest_cursor   = r_onewest;
    assign o_latest_assigned = r_olatest;
    assign o_cursor_gap      = r_ogap;
    assign o_update_drops    = r_odropped;
    assign o_last            = r_olast;

`include "protected_event_log_buffer_top_assert.svh"

    `PELB_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count past depth")
    `PELB_ASSERT_SAME(a_last_idle, r_ov && r_olast, !busy, "last result while busy")
    `PELB_ASSERT_SAME(a_compact_order, r_state == S_COMPACT, r_wj <= r_ridx, "write passed read")
    `PELB_ASSERT_NEXT(a_append_grows, r_state == S_APPEND, r_count == $past(r_count) + CW'(1), "append lost")

endmodule
`default_nettype wire
